/* design/hcc_pkg.sv */
// Shared types and constants for the hue cycle color block.
package hcc_pkg;

    // Configuration register index width and write data width
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_CYCLE_ENABLE = 2'd0;
    localparam cfg_index_t REG_BASE_COLOR   = 2'd1;
    localparam cfg_index_t REG_CYCLE_SPEED  = 2'd2;

    // 0.002 turns as unsigned Q0.32
    localparam logic [23:0] STEP_K = 24'd8589935;

    localparam logic [31:0] BASE_COLOR_RESET  = 32'hFFFF_FFFF;
    localparam logic [15:0] CYCLE_SPEED_RESET = 16'd256;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MSTEP = 6'b000010,
        ST_MLO   = 6'b000100,
        ST_MHI   = 6'b001000,
        ST_ADV   = 6'b010000,
        ST_COLOR = 6'b100000
    } state_t;

endpackage

/* design/hue_cycle_color.sv */
// Rainbow hue cycler: phase advance through one shared 24x24 multiplier, HSV to ARGB.
// With cycling on, each item passes the states MSTEP, MLO, MHI, ADV and COLOR; with it off, only COLOR.
// With cycling on, an item takes three passes through the shared multiplier, a phase add and a
// color stage; the color stage holds until the output register is free. One item is in work at a time.
// The next item is taken while a finished result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the hue phase and loads register defaults.
module hue_cycle_color #(
    parameter int HUE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  hcc_pkg::cfg_index_t            cfg_index,
    input  logic [hcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [23:0] elapsed_time
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata    // [31:0] current_color, [55:32] current_hue
);
    import hcc_pkg::*;

    localparam int RAMP_W = HUE_BITS + 9;

    state_t                state_reg, state_next;
    logic                  cycle_enable_reg;
    logic [31:0]           base_color_reg;
    logic [15:0]           cycle_speed_reg;
    logic [23:0]           time_reg, time_next;
    logic [39:0]           step_reg, step_next;
    logic [63:0]           acc_reg, acc_next;
    logic [HUE_BITS-1:0]   phase_reg, phase_next;
    logic [31:0]           color_reg, color_next;
    logic [23:0]           hue_reg;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [23:0]           mul_a;
    logic [23:0]           mul_b;
    logic [47:0]           mul_p;
    logic [HUE_BITS-1:0]   adv;
    logic [HUE_BITS+2:0]   scaled;
    logic [2:0]            sector;
    logic [HUE_BITS-1:0]   frac;
    logic [HUE_BITS:0]     up_x;
    logic [HUE_BITS:0]     down_x;
    logic [RAMP_W-1:0]     up_prod;
    logic [RAMP_W-1:0]     down_prod;
    logic [7:0]            ramp_up;
    logic [7:0]            ramp_down;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [23:0]           hue_scaled;
    logic                  out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_enable_reg <= 1'b0;
            base_color_reg   <= BASE_COLOR_RESET;
            cycle_speed_reg  <= CYCLE_SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CYCLE_ENABLE: cycle_enable_reg <= cfg_wdata[0];
                REG_BASE_COLOR:   base_color_reg   <= cfg_wdata[31:0];
                REG_CYCLE_SPEED:  cycle_speed_reg  <= cfg_wdata[15:0];
                default:          ;
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MSTEP:
            begin
                mul_a = STEP_K;
                mul_b = {8'd0, cycle_speed_reg};
            end
            ST_MLO:
            begin
                mul_a = step_reg[23:0];
                mul_b = time_reg;
            end
            ST_MHI:
            begin
                mul_a = {8'd0, step_reg[39:24]};
                mul_b = time_reg;
            end
            default:
            begin
                mul_a = 24'd0;
                mul_b = 24'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Zero elapsed time means one fixed frame step
    assign adv = (time_reg == 24'd0) ? step_reg[39 -: HUE_BITS] : acc_reg[55 -: HUE_BITS];

    // HSV to RGB with S = V = 1: sector and fractional ramp
    assign scaled    = ({3'd0, phase_reg} << 2) + ({3'd0, phase_reg} << 1);
    assign sector    = scaled[HUE_BITS+2:HUE_BITS];
    assign frac      = scaled[HUE_BITS-1:0];
    assign up_x      = {1'b0, frac};
    assign down_x    = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, frac};
    // x * 255 as (x << 8) - x
    assign up_prod   = ({8'd0, up_x} << 8) - {8'd0, up_x};
    assign down_prod = ({8'd0, down_x} << 8) - {8'd0, down_x};
    assign ramp_up   = up_prod[HUE_BITS+7:HUE_BITS];
    assign ramp_down = down_prod[HUE_BITS+7:HUE_BITS];

    always_comb
    begin
        case (sector)
            3'd0:
            begin
                red = 8'hFF; green = ramp_up; blue = 8'h00;
            end
            3'd1:
            begin
                red = ramp_down; green = 8'hFF; blue = 8'h00;
            end
            3'd2:
            begin
                red = 8'h00; green = 8'hFF; blue = ramp_up;
            end
            3'd3:
            begin
                red = 8'h00; green = ramp_down; blue = 8'hFF;
            end
            3'd4:
            begin
                red = ramp_up; green = 8'h00; blue = 8'hFF;
            end
            default:
            begin
                red = 8'hFF; green = 8'h00; blue = ramp_down;
            end
        endcase
    end

    // Report the phase on 24 bits
    generate
        if (HUE_BITS >= 24)
        begin : g_hue_trunc
            assign hue_scaled = phase_reg[HUE_BITS-1 -: 24];
        end
        else
        begin : g_hue_fill
            assign hue_scaled = {phase_reg, {(24-HUE_BITS){1'b0}}};
        end
    endgenerate

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        time_next     = time_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        color_next    = color_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    time_next  = s_tdata;
                    state_next = cycle_enable_reg ? ST_MSTEP : ST_COLOR;
                end
            end
            ST_MSTEP:
            begin
                step_next  = mul_p[39:0];
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                acc_next   = {16'd0, mul_p};
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                acc_next   = acc_reg + {mul_p[39:0], 24'd0};
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                phase_next = phase_reg + adv;
                state_next = ST_COLOR;
            end
            ST_COLOR:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    color_next    = cycle_enable_reg ?
                                    {base_color_reg[31:24], red, green, blue} : base_color_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        color_reg <= color_next;
        if (state_reg == ST_COLOR && out_free)
        begin
            hue_reg <= hue_scaled;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {8'd0, hue_reg, color_reg};

endmodule

/* test/tb_top.sv */
// Testbench for hue_cycle_color: bit-accurate hue predictor, stream stimulus and result checks.
`timescale 1ns / 100ps

module tb_top;
    import hcc_pkg::*;

    // 0.002 turns as unsigned Q0.32
    localparam logic [63:0] HUE_STEP_Q32 = 64'd8589935;
    localparam cfg_index_t  REG_UNUSED   = 2'd3;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          MAX_REPORTS  = 10;
    // Room for far more expectations than the block can hold in flight
    localparam int          EXP_DEPTH    = 16;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct packed {
        logic [31:0] color;
        logic [23:0] hue;
    } color_hue_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    cfg_index_t  cfg_index = REG_CYCLE_ENABLE;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;

    // Mirror of the block's registers and hue phase
    logic        model_enable = 1'b0;
    logic [31:0] model_base   = 32'hFFFF_FFFF;
    logic [15:0] model_speed  = 16'd256;
    logic [23:0] model_hue    = '0;

    // Expected results in order: written at exp_wr, read at exp_rd
    color_hue_t expected_colors[EXP_DEPTH];
    int exp_wr        = 0;
    int exp_rd        = 0;

    int items_sent    = 0;
    int items_cycled  = 0;
    int results_seen  = 0;
    int errors        = 0;
    int burst_left    = 0;
    int tx_gap_max    = 0;
    int rx_mode       = RX_ALWAYS;
    int rx_tick       = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    hue_cycle_color dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [23:0] elapsed_time
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [31:0] current_color, [55:32] current_hue
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Phase advance for one tick: frame step when elapsed time is zero
    function automatic logic [23:0] phase_advance(input logic [15:0] speed,
                                                  input logic [23:0] elapsed);
        logic [63:0] frame_step;
        logic [63:0] timed_step;
        frame_step = HUE_STEP_Q32 * {48'd0, speed};
        timed_step = frame_step * {40'd0, elapsed};
        if (elapsed != 24'd0)
            return timed_step[55:32];
        return frame_step[39:16];
    endfunction

    // Saturated, full-value HSV to packed RGB
    function automatic logic [23:0] hue_rgb(input logic [23:0] hue);
        logic [26:0] scaled;
        logic [23:0] frac;
        logic [32:0] rise;
        logic [32:0] fall;
        logic [7:0]  up;
        logic [7:0]  down;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        scaled = {3'd0, hue} * 27'd6;
        frac   = scaled[23:0];
        rise   = {9'd0, frac} * 33'd255;
        fall   = ((33'd1 << 24) - {9'd0, frac}) * 33'd255;
        up     = rise[31:24];
        down   = fall[31:24];
        case (scaled[26:24])
            3'd0:    begin r = 8'hFF; g = up;    b = 8'h00; end
            3'd1:    begin r = down;  g = 8'hFF; b = 8'h00; end
            3'd2:    begin r = 8'h00; g = 8'hFF; b = up;    end
            3'd3:    begin r = 8'h00; g = down;  b = 8'hFF; end
            3'd4:    begin r = up;    g = 8'h00; b = 8'hFF; end
            default: begin r = 8'hFF; g = 8'h00; b = down;  end
        endcase
        return {r, g, b};
    endfunction

    // Receiver: stall pattern per mode, long hold-off on request
    always @(negedge clk)
    begin
        rx_tick = rx_tick + 1;
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
                RX_PATTERN: m_tready <= ((rx_tick % 7) < 3);
                default:    m_tready <= 1'b1;
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        color_hue_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen = results_seen + 1;
            if (exp_wr == exp_rd)
            begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result %h", $realtime, m_tdata);
            end
            else
            begin
                want   = expected_colors[exp_rd % EXP_DEPTH];
                exp_rd = exp_rd + 1;
                if (m_tdata[31:0] !== want.color || m_tdata[55:32] !== want.hue)
                begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result %0d color exp %h got %h, hue exp %h got %h",
                                 $realtime, results_seen, want.color, m_tdata[31:0],
                                 want.hue, m_tdata[55:32]);
                end
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CYCLE_ENABLE: model_enable = value[0];
            REG_BASE_COLOR:   model_base   = value;
            REG_CYCLE_SPEED:  model_speed  = value[15:0];
            default:          ;
        endcase
    endtask

    // Offer one elapsed-time item; predict its result once accepted
    task automatic send_tick(input logic [23:0] elapsed);
        color_hue_t want;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= elapsed;
        do
            @(posedge clk);
        while (!s_tready);
        if (model_enable)
        begin
            model_hue    = model_hue + phase_advance(model_speed, elapsed);
            want.color   = {model_base[31:24], hue_rgb(model_hue)};
            items_cycled = items_cycled + 1;
        end
        else
            want.color = model_base;
        want.hue = model_hue;
        expected_colors[exp_wr % EXP_DEPTH] = want;
        exp_wr = exp_wr + 1;
        items_sent = items_sent + 1;
        @(negedge clk);
        if (burst_left > 0)
            burst_left = burst_left - 1;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Go idle: stop offering, wait for every result, then let the pipeline settle
    task automatic drain;
        s_tvalid <= 1'b0;
        wait (exp_wr == exp_rd);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_elapsed;
        logic [23:0] v;
        v = 24'($urandom());
        case ($urandom_range(0, 9))
            0, 1:    return 24'd0;
            2:       return 24'hFF_FFFF;
            3:       return 24'($urandom_range(1, 255));
            default: return v >> $urandom_range(0, 23);
        endcase
    endfunction

    task automatic test_passthrough;
        send_tick(24'd0);
        send_tick(24'hFF_FFFF);
        drain();
        write_reg(REG_BASE_COLOR, 32'h0000_0000);
        send_tick(24'h00_0001);
        drain();
        write_reg(REG_BASE_COLOR, 32'h5A3C_96E1);
        send_tick(24'h80_0000);
        drain();
    endtask

    task automatic test_register_masking;
        // Bit 0 clear: cycling stays off despite the set upper bits
        write_reg(REG_CYCLE_ENABLE, 32'hFFFF_FFFE);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_tick(24'h00_0100);
        drain();
        write_reg(REG_CYCLE_SPEED, 32'hABCD_0100);
        write_reg(REG_CYCLE_ENABLE, 32'h8000_0001);
        send_tick(24'd0);
        drain();
    endtask

    task automatic test_frame_step;
        write_reg(REG_CYCLE_SPEED, 32'd1);
        send_tick(24'd1);
        send_tick(24'd0);
        drain();
        write_reg(REG_CYCLE_SPEED, 32'd0);
        send_tick(24'hFF_FFFF);
        drain();
        write_reg(REG_CYCLE_SPEED, 32'h0000_FFFF);
        send_tick(24'd0);
        send_tick(24'hFF_FFFF);
        drain();
    endtask

    task automatic test_sector_walk;
        // Just over a sixth of a turn per frame: visits every sector and wraps
        write_reg(REG_BASE_COLOR, 32'h8012_3456);
        write_reg(REG_CYCLE_SPEED, 32'd21400);
        repeat (7) send_tick(24'd0);
        drain();
    endtask

    task automatic test_random_phases;
        logic [31:0] w;
        for (int phase = 0; phase < 10; phase++)
        begin
            tx_gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 10);
            rx_mode    = phase % 3;
            w    = $urandom();
            w[0] = (phase == 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            write_reg(REG_CYCLE_ENABLE, w);
            case (phase)
                0:       w = 32'h0000_0000;
                1:       w = 32'hFFFF_FFFF;
                default: w = $urandom();
            endcase
            write_reg(REG_BASE_COLOR, w);
            w = $urandom();
            case (phase)
                2:       w[15:0] = 16'h0000;
                3:       w[15:0] = 16'hFFFF;
                4:       w[15:0] = 16'($urandom_range(1, 16));
                default: ;
            endcase
            write_reg(REG_CYCLE_SPEED, w);
            repeat (48) send_tick(rand_elapsed());
            drain();
        end
    endtask

    task automatic test_backpressure;
        write_reg(REG_CYCLE_ENABLE, 32'd1);
        write_reg(REG_CYCLE_SPEED, 32'd3000);
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        hold_req   = 400;
        repeat (40) send_tick(rand_elapsed());
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_passthrough();
        test_register_masking();
        test_frame_step();
        test_sector_walk();
        test_random_phases();
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (exp_wr != exp_rd)
        begin
            errors = errors + (exp_wr - exp_rd);
            $display("%0d expected results never arrived", exp_wr - exp_rd);
        end
        $display("Covered %0d ticks (%0d with hue cycling), %0d results checked, %0d errors",
                 items_sent, items_cycled, results_seen, errors);
        $display("Included register masking, speed extremes, all six sectors, long stall");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* hue_cycle_color.f */
design/hcc_pkg.sv
design/hue_cycle_color.sv
test/tb_top.sv
